### rtl/core/tlq_pkg.sv
// types, constants and helpers shared by the two-level task queue
`default_nettype none

package tlq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int TASK_BITS   = 80;
   localparam int WORD_BITS   = 80;
   localparam int LOW_BITS    = 64;
   localparam int HIGH_BITS   = 16;
   localparam int LEVEL_BITS  = 4;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ENQ_NORMAL   = 2'd0,
      OP_ENQ_PRIORITY = 2'd1,
      OP_DEQUEUE      = 2'd2,
      OP_PROMOTE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_NO_ROOM = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic       push_normal;
      logic       push_priority;
      logic       pop_normal;
      logic       pop_priority;
      status_type status;
   } action_type;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] ptr);
      logic [PTR_BITS-1:0] result;
      if (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_BITS'(1);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### rtl/core/two_level_task_queue_with_promotion.sv
// two-level task queue: normal and priority fifos in ram, with promotion
//
// channel   ports                                   handshake
// request   req_op, req_task_low, req_task_high     start high while busy low
// response  rsp_status, rsp_out_low, rsp_out_high,  rsp_valid high one cycle
//           rsp_from_priority, rsp_normal_level,
//           rsp_priority_level
//
// in each transaction the accept edge reads both fifo rams,
// the next edge applies pointer, fill and ram write updates and registers
// the response, which is shown while the next transaction may be accepted.
// synchronous reset empties both queues; ram contents stay undefined.
// the receiver cannot stall; busy is high only in the update cycle.
`default_nettype none

module two_level_task_queue_with_promotion (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [1:0]   req_op,
   input  wire logic [63:0]  req_task_low,
   input  wire logic [15:0]  req_task_high,
   output logic              rsp_valid,
   output logic      [1:0]   rsp_status,
   output logic      [63:0]  rsp_out_low,
   output logic      [15:0]  rsp_out_high,
   output logic              rsp_from_priority,
   output logic      [3:0]   rsp_normal_level,
   output logic      [3:0]   rsp_priority_level
);

   localparam int TB = tlq_pkg::TASK_BITS;
   localparam int WB = tlq_pkg::WORD_BITS;
   localparam int PB = tlq_pkg::PTR_BITS;
   localparam int FB = tlq_pkg::FILL_BITS;
   localparam int LB = tlq_pkg::LEVEL_BITS;

   tlq_pkg::state_type  state_ff, state_in;
   tlq_pkg::action_type act_ff, act_in;
   logic [TB-1:0]       task_ff;

   logic [PB-1:0] n_wr_ff, n_wr_in, n_rd_ff, n_rd_in;
   logic [PB-1:0] p_wr_ff, p_wr_in, p_rd_ff, p_rd_in;
   logic [FB-1:0] n_fill_ff, n_fill_in, p_fill_ff, p_fill_in;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [63:0]   rsp_low_ff;
   logic [15:0]   rsp_high_ff;
   logic          rsp_fromp_ff;
   logic [LB-1:0] rsp_nlevel_ff, rsp_plevel_ff;

   logic          accept;
   logic          exec;
   logic          n_full, p_full, n_empty, p_empty;
   tlq_pkg::op_type op;

   logic [WB-1:0]    req_word;
   logic [TB+WB-1:0] req_word_ext;
   logic [TB-1:0]    req_task;

   logic          n_we, p_we;
   logic [TB-1:0] p_wdata;
   logic [TB-1:0] n_rdata, p_rdata;
   logic [TB-1:0] out_task;
   logic [TB+WB-1:0] out_task_ext;
   logic [WB-1:0] out_word;
   logic [FB+LB-1:0] n_level_ext, p_level_ext;

   assign accept  = start && (state_ff == tlq_pkg::ST_IDLE);
   assign exec    = (state_ff == tlq_pkg::ST_EXEC);
   assign op      = tlq_pkg::op_type'(req_op);
   assign n_full  = (n_fill_ff == FB'(tlq_pkg::QUEUE_DEPTH));
   assign p_full  = (p_fill_ff == FB'(tlq_pkg::QUEUE_DEPTH));
   assign n_empty = (n_fill_ff == '0);
   assign p_empty = (p_fill_ff == '0);

   assign req_word     = {req_task_high, req_task_low};
   assign req_word_ext = {{TB{1'b0}}, req_word};
   assign req_task     = req_word_ext[TB-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tlq_pkg::ST_EXEC;
            end
         end
         tlq_pkg::ST_EXEC: begin
            state_in = tlq_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy = 1'b0;
      unique case (state_ff)
         tlq_pkg::ST_IDLE: busy = 1'b0;
         tlq_pkg::ST_EXEC: busy = 1'b1;
         default:          busy = 1'b0;
      endcase
   end

   // decision taken on the fill levels at accept
   always_comb begin
      act_in = '{push_normal: 1'b0, push_priority: 1'b0, pop_normal: 1'b0,
                 pop_priority: 1'b0, status: tlq_pkg::STATUS_DONE};
      unique case (op)
         tlq_pkg::OP_ENQ_NORMAL: begin
            if (n_full) begin
               act_in.status = tlq_pkg::STATUS_FULL;
            end else begin
               act_in.push_normal = 1'b1;
            end
         end
         tlq_pkg::OP_ENQ_PRIORITY: begin
            if (p_full) begin
               act_in.status = tlq_pkg::STATUS_FULL;
            end else begin
               act_in.push_priority = 1'b1;
            end
         end
         tlq_pkg::OP_DEQUEUE: begin
            priority if (!p_empty) begin
               act_in.pop_priority = 1'b1;
            end else if (!n_empty) begin
               act_in.pop_normal = 1'b1;
            end else begin
               act_in.status = tlq_pkg::STATUS_EMPTY;
            end
         end
         tlq_pkg::OP_PROMOTE: begin
            priority if (n_empty) begin
               act_in.status = tlq_pkg::STATUS_EMPTY;
            end else if (p_full) begin
               act_in.status = tlq_pkg::STATUS_NO_ROOM;
            end else begin
               act_in.pop_normal    = 1'b1;
               act_in.push_priority = 1'b1;
            end
         end
         default: begin
            act_in.status = tlq_pkg::STATUS_DONE;
         end
      endcase
   end

   // update of pointers, fills and ram writes in the exec cycle
   assign n_we    = exec && act_ff.push_normal;
   assign p_we    = exec && act_ff.push_priority;
   assign p_wdata = act_ff.pop_normal ? n_rdata : task_ff;

   always_comb begin
      n_wr_in   = n_wr_ff;
      n_rd_in   = n_rd_ff;
      p_wr_in   = p_wr_ff;
      p_rd_in   = p_rd_ff;
      n_fill_in = n_fill_ff;
      p_fill_in = p_fill_ff;
      if (exec) begin
         if (act_ff.push_normal) begin
            n_wr_in = tlq_pkg::ptr_next(n_wr_ff);
         end
         if (act_ff.pop_normal) begin
            n_rd_in = tlq_pkg::ptr_next(n_rd_ff);
         end
         if (act_ff.push_priority) begin
            p_wr_in = tlq_pkg::ptr_next(p_wr_ff);
         end
         if (act_ff.pop_priority) begin
            p_rd_in = tlq_pkg::ptr_next(p_rd_ff);
         end
         n_fill_in = n_fill_ff + FB'(act_ff.push_normal) - FB'(act_ff.pop_normal);
         p_fill_in = p_fill_ff + FB'(act_ff.push_priority) - FB'(act_ff.pop_priority);
      end
   end

   // dequeued task for the response
   always_comb begin
      priority if (act_ff.pop_priority) begin
         out_task = p_rdata;
      end else if (act_ff.pop_normal && !act_ff.push_priority) begin
         out_task = n_rdata;
      end else begin
         out_task = '0;
      end
   end

   assign out_task_ext = {{WB{1'b0}}, out_task};
   assign out_word     = out_task_ext[WB-1:0];
   assign n_level_ext  = {{LB{1'b0}}, n_fill_in};
   assign p_level_ext  = {{LB{1'b0}}, p_fill_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlq_pkg::ST_IDLE;
         n_wr_ff      <= '0;
         n_rd_ff      <= '0;
         p_wr_ff      <= '0;
         p_rd_ff      <= '0;
         n_fill_ff    <= '0;
         p_fill_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         act_ff       <= '{push_normal: 1'b0, push_priority: 1'b0, pop_normal: 1'b0,
                           pop_priority: 1'b0, status: tlq_pkg::STATUS_DONE};
      end else begin
         state_ff     <= state_in;
         n_wr_ff      <= n_wr_in;
         n_rd_ff      <= n_rd_in;
         p_wr_ff      <= p_wr_in;
         p_rd_ff      <= p_rd_in;
         n_fill_ff    <= n_fill_in;
         p_fill_ff    <= p_fill_in;
         rsp_valid_ff <= exec;
         if (accept) begin
            act_ff <= act_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         task_ff <= req_task;
      end
      if (exec) begin
         rsp_status_ff <= act_ff.status;
         rsp_low_ff    <= out_word[tlq_pkg::LOW_BITS-1:0];
         rsp_high_ff   <= out_word[WB-1:tlq_pkg::LOW_BITS];
         rsp_fromp_ff  <= act_ff.pop_priority;
         rsp_nlevel_ff <= n_level_ext[LB-1:0];
         rsp_plevel_ff <= p_level_ext[LB-1:0];
      end
   end

   tlq_ram #(
      .WIDTH     (TB),
      .DEPTH     (tlq_pkg::QUEUE_DEPTH),
      .ADDR_BITS (PB)
   ) u_normal_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_wr_ff),
      .wr_data (task_ff),
      .rd_en   (accept),
      .rd_addr (n_rd_ff),
      .rd_data (n_rdata)
   );

   tlq_ram #(
      .WIDTH     (TB),
      .DEPTH     (tlq_pkg::QUEUE_DEPTH),
      .ADDR_BITS (PB)
   ) u_priority_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_wr_ff),
      .wr_data (p_wdata),
      .rd_en   (accept),
      .rd_addr (p_rd_ff),
      .rd_data (p_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_low        = rsp_low_ff;
   assign rsp_out_high       = rsp_high_ff;
   assign rsp_from_priority  = rsp_fromp_ff;
   assign rsp_normal_level   = rsp_nlevel_ff;
   assign rsp_priority_level = rsp_plevel_ff;

endmodule

`default_nettype wire

### rtl/core/tlq_ram.sv
// simple dual-port synchronous ram with registered read data
`default_nettype none

module tlq_ram #(
   parameter int WIDTH     = 80,
   parameter int DEPTH     = 8,
   parameter int ADDR_BITS = 3
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### tb/two_level_task_queue_with_promotion_tb.sv
// testbench for the two-level task queue: directed and random requests checked by a scoreboard
`timescale 1ns / 1ps

module two_level_task_queue_with_promotion_tb;

   localparam int NORMAL_Q   = 0;
   localparam int PRIORITY_Q = 1;

   class task_queue_scoreboard;
      typedef struct {
         tlq_pkg::status_type status;
         logic [63:0]         out_low;
         logic [15:0]         out_high;
         logic                from_priority;
         logic [3:0]          normal_level;
         logic [3:0]          priority_level;
      } response_type;

      logic [tlq_pkg::WORD_BITS-1:0] slot [2][tlq_pkg::QUEUE_DEPTH];
      int                            wr_ptr [2];
      int                            rd_ptr [2];
      int                            fill [2];
      response_type                  pending [$];
      int                            error_count;

      function new();
         foreach (fill[q]) begin
            wr_ptr[q] = 0;
            rd_ptr[q] = 0;
            fill[q]   = 0;
         end
         error_count = 0;
      endfunction

      task report_error(string msg);
         $display("%0t ns: mismatch: %s", $realtime, msg);
         error_count++;
      endtask

      function void push_task(int q, logic [tlq_pkg::WORD_BITS-1:0] word);
         slot[q][wr_ptr[q]] = word;
         wr_ptr[q] = (wr_ptr[q] + 1) % tlq_pkg::QUEUE_DEPTH;
         fill[q]++;
      endfunction

      function logic [tlq_pkg::WORD_BITS-1:0] pop_task(int q);
         logic [tlq_pkg::WORD_BITS-1:0] word;
         word = slot[q][rd_ptr[q]];
         rd_ptr[q] = (rd_ptr[q] + 1) % tlq_pkg::QUEUE_DEPTH;
         fill[q]--;
         return word;
      endfunction

      function void note_request(tlq_pkg::op_type op, logic [63:0] lo, logic [15:0] hi);
         response_type                  rsp;
         logic [tlq_pkg::WORD_BITS-1:0] word;
         int                            q;
         word = {hi, lo};
         if (tlq_pkg::TASK_BITS < tlq_pkg::WORD_BITS) begin
            word &= ~({tlq_pkg::WORD_BITS{1'b1}} << tlq_pkg::TASK_BITS);
         end
         rsp.status        = tlq_pkg::STATUS_DONE;
         rsp.out_low       = '0;
         rsp.out_high      = '0;
         rsp.from_priority = 1'b0;
         case (op)
            tlq_pkg::OP_ENQ_NORMAL, tlq_pkg::OP_ENQ_PRIORITY: begin
               q = (op == tlq_pkg::OP_ENQ_PRIORITY) ? PRIORITY_Q : NORMAL_Q;
               if (fill[q] >= tlq_pkg::QUEUE_DEPTH) begin
                  rsp.status = tlq_pkg::STATUS_FULL;
               end else begin
                  push_task(q, word);
               end
            end
            tlq_pkg::OP_DEQUEUE: begin
               if (fill[PRIORITY_Q] > 0) begin
                  {rsp.out_high, rsp.out_low} = pop_task(PRIORITY_Q);
                  rsp.from_priority = 1'b1;
               end else if (fill[NORMAL_Q] > 0) begin
                  {rsp.out_high, rsp.out_low} = pop_task(NORMAL_Q);
               end else begin
                  rsp.status = tlq_pkg::STATUS_EMPTY;
               end
            end
            tlq_pkg::OP_PROMOTE: begin
               if (fill[NORMAL_Q] == 0) begin
                  rsp.status = tlq_pkg::STATUS_EMPTY;
               end else if (fill[PRIORITY_Q] >= tlq_pkg::QUEUE_DEPTH) begin
                  rsp.status = tlq_pkg::STATUS_NO_ROOM;
               end else begin
                  push_task(PRIORITY_Q, pop_task(NORMAL_Q));
               end
            end
         endcase
         rsp.normal_level   = 4'(fill[NORMAL_Q]);
         rsp.priority_level = 4'(fill[PRIORITY_Q]);
         pending.push_back(rsp);
      endfunction

      task check_response(logic [1:0] status, logic [63:0] out_low, logic [15:0] out_high,
                          logic from_priority, logic [3:0] normal_level,
                          logic [3:0] priority_level);
         response_type want;
         if (pending.size() == 0) begin
            report_error("response with no transaction pending");
         end else begin
            want = pending.pop_front();
            if (status !== want.status)
               report_error($sformatf("status got %0d want %0d", status, want.status));
            if (out_low !== want.out_low)
               report_error($sformatf("out_low got %h want %h", out_low, want.out_low));
            if (out_high !== want.out_high)
               report_error($sformatf("out_high got %h want %h", out_high, want.out_high));
            if (from_priority !== want.from_priority)
               report_error($sformatf("from_priority got %b want %b",
                                      from_priority, want.from_priority));
            if (normal_level !== want.normal_level)
               report_error($sformatf("normal_level got %0d want %0d",
                                      normal_level, want.normal_level));
            if (priority_level !== want.priority_level)
               report_error($sformatf("priority_level got %0d want %0d",
                                      priority_level, want.priority_level));
         end
      endtask
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   tlq_pkg::op_type req_op = tlq_pkg::OP_ENQ_NORMAL;
   logic [63:0]     req_task_low = '0;
   logic [15:0]     req_task_high = '0;
   logic            rsp_valid;
   logic [1:0]      rsp_status;
   logic [63:0]     rsp_out_low;
   logic [15:0]     rsp_out_high;
   logic            rsp_from_priority;
   logic [3:0]      rsp_normal_level;
   logic [3:0]      rsp_priority_level;

   task_queue_scoreboard sb;
   int                   idle_pct = 0;
   int                   phase_idle [3] = '{0, 62, 36};

   two_level_task_queue_with_promotion dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_task_low       (req_task_low),
      .req_task_high      (req_task_high),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_low        (rsp_out_low),
      .rsp_out_high       (rsp_out_high),
      .rsp_from_priority  (rsp_from_priority),
      .rsp_normal_level   (rsp_normal_level),
      .rsp_priority_level (rsp_priority_level)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3ms;
      $display("two_level_task_queue_with_promotion_tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_request(req_op, req_task_low, req_task_high);
         end
         if (rsp_valid) begin
            sb.check_response(rsp_status, rsp_out_low, rsp_out_high, rsp_from_priority,
                              rsp_normal_level, rsp_priority_level);
         end
      end
   end

   task automatic send_request(input tlq_pkg::op_type op, input logic [63:0] lo,
                               input logic [15:0] hi);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_op        <= op;
      req_task_low  <= lo;
      req_task_high <= hi;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [63:0] random_low();
      return {$urandom, $urandom};
   endfunction

   initial begin
      int              enq_bias;
      int              roll;
      int              drain_cycles;
      tlq_pkg::op_type op;
      logic [63:0]     lo;
      logic [15:0]     hi;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queues
      send_request(tlq_pkg::OP_DEQUEUE, '1, '1);
      send_request(tlq_pkg::OP_PROMOTE, '0, '0);
      // fill normal queue, extremes of the task word
      send_request(tlq_pkg::OP_ENQ_NORMAL, '1, '1);
      send_request(tlq_pkg::OP_ENQ_NORMAL, '0, '0);
      send_request(tlq_pkg::OP_ENQ_NORMAL, 64'haaaa_aaaa_aaaa_aaaa, 16'h5555);
      send_request(tlq_pkg::OP_ENQ_NORMAL, 64'h5555_5555_5555_5555, 16'haaaa);
      repeat (4) send_request(tlq_pkg::OP_ENQ_NORMAL, random_low(), 16'($urandom));
      send_request(tlq_pkg::OP_ENQ_NORMAL, '1, '1);
      send_request(tlq_pkg::OP_PROMOTE, '0, '0);
      send_request(tlq_pkg::OP_PROMOTE, '0, '0);
      // fill priority queue, then refused enqueue and refused promote
      repeat (6) send_request(tlq_pkg::OP_ENQ_PRIORITY, random_low(), 16'($urandom));
      send_request(tlq_pkg::OP_ENQ_PRIORITY, '0, '1);
      send_request(tlq_pkg::OP_PROMOTE, '1, '0);
      send_request(tlq_pkg::OP_DEQUEUE, '0, '0);
      send_request(tlq_pkg::OP_DEQUEUE, '0, '0);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = phase_idle[phase];
         for (int n = 0; n < 234; n++) begin
            if (n % 40 == 0) begin
               enq_bias = 20 + 30 * $urandom_range(2);
            end
            roll = $urandom_range(99);
            if (roll < enq_bias) begin
               op = $urandom_range(1) ? tlq_pkg::OP_ENQ_PRIORITY : tlq_pkg::OP_ENQ_NORMAL;
            end else if (roll < enq_bias + (100 - enq_bias) / 2) begin
               op = tlq_pkg::OP_DEQUEUE;
            end else begin
               op = tlq_pkg::OP_PROMOTE;
            end
            lo = random_low();
            hi = 16'($urandom);
            case ($urandom_range(15))
               0: begin
                  lo = '1;
                  hi = '1;
               end
               1: begin
                  lo = '0;
                  hi = '0;
               end
               default: ;
            endcase
            send_request(op, lo, hi);
         end
      end
      start <= 1'b0;

      drain_cycles = 0;
      while (sb.pending.size() != 0 && drain_cycles < 200) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      if (sb.pending.size() != 0) begin
         sb.report_error($sformatf("%0d transactions never answered", sb.pending.size()));
      end
      if (sb.error_count == 0) begin
         $display("two_level_task_queue_with_promotion_tb: done, clean");
      end else begin
         $display("two_level_task_queue_with_promotion_tb: done, errors");
      end
      $finish;
   end

endmodule

### two_level_task_queue_with_promotion.f
rtl/core/tlq_pkg.sv
rtl/core/tlq_ram.sv
rtl/core/two_level_task_queue_with_promotion.sv
tb/two_level_task_queue_with_promotion_tb.sv
